// File: sv/i2t_pkg.sv
package i2t_pkg;

   // width of the integer being converted
   localparam int VALUE_BITS = 32;
   localparam int RADIX_BITS = 6;
   localparam int CHAR_BITS = 8;

   // digit store addressing and digit count
   localparam int ADDR_BITS = $clog2(VALUE_BITS);
   localparam int COUNT_BITS = $clog2(VALUE_BITS + 1);

   // divider: quotient bits produced per cycle, division steps per digit
   localparam int STEP_BITS = 8;
   localparam int STEPS_PER_DIGIT = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD_BITS = STEPS_PER_DIGIT * STEP_BITS;
   localparam int STEP_CNT_BITS = (STEPS_PER_DIGIT > 1) ? $clog2(STEPS_PER_DIGIT) : 1;

   // base limits
   localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(2);
   localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(36);

   // character codes
   localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_A = 8'h41;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic [RADIX_BITS-1:0]        radix;
   } req_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] text_char;
      logic                 last_char;
   } rsp_type;

   // classified job handed from front to back
   typedef struct packed {
      logic                  negative;
      logic [VALUE_BITS-1:0] magnitude;
      logic [RADIX_BITS-1:0] base;
   } job_type;

   // digit value to ascii
   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [RADIX_BITS-1:0] d);
      logic [CHAR_BITS-1:0] c;
      if (d < RADIX_BITS'(10)) begin
         c = CHAR_ZERO + CHAR_BITS'(d);
      end else if (d < RADIX_MAX) begin
         c = CHAR_A + CHAR_BITS'(d) - CHAR_BITS'(10);
      end else begin
         c = CHAR_ZERO;
      end
      return c;
   endfunction

endpackage

// File: sv/i2t_front.sv
module i2t_front
   import i2t_pkg::*;
(
   input  req_type req_word,
   output job_type job_word
);

   logic [VALUE_BITS-1:0] raw;

   // sign split and base saturation
   always_comb begin
      raw = VALUE_BITS'(req_word.value);
      job_word.negative = raw[VALUE_BITS-1];
      job_word.magnitude = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
      if (req_word.radix < RADIX_MIN) begin
         job_word.base = RADIX_MIN;
      end else if (req_word.radix > RADIX_MAX) begin
         job_word.base = RADIX_MAX;
      end else begin
         job_word.base = req_word.radix;
      end
   end

endmodule

// File: sv/i2t_queue.sv
module i2t_queue
   import i2t_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_word,
   input  logic    pop,
   output job_type pop_word,
   output logic    empty,
   output logic    full
);

   // two entry queue between front and back
   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   assign empty = (fill_ff == 2'd0);
   assign full = (fill_ff == 2'd2);
   assign pop_word = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in = fill_ff;
      if (push && !full) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop && !empty) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if ((push && !full) && !(pop && !empty)) begin
         fill_in = fill_ff + 2'd1;
      end else if (!(push && !full) && (pop && !empty)) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// File: sv/i2t_back.sv
module i2t_back
   import i2t_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    job_ready,
   input  job_type job_word,
   output logic    job_take,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIVIDE = 3'd1;
   localparam logic [2:0] S_SIGN = 3'd2;
   localparam logic [2:0] S_FETCH = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [PAD_BITS-1:0]      work_ff, work_in;
   logic [RADIX_BITS-1:0]    rem_ff, rem_in;
   logic [RADIX_BITS-1:0]    base_ff, base_in;
   logic                     neg_ff, neg_in;
   logic [STEP_CNT_BITS-1:0] step_ff, step_in;
   logic [COUNT_BITS-1:0]    idx_ff, idx_in;
   logic [RADIX_BITS-1:0]    rd_data_ff;
   logic [RADIX_BITS-1:0]    digit_mem [VALUE_BITS];

   logic [PAD_BITS-1:0]      div_work;
   logic [RADIX_BITS:0]      div_rem;
   logic                     digit_done;
   logic                     wr_en;
   logic [ADDR_BITS-1:0]     wr_addr;
   logic [ADDR_BITS-1:0]     rd_addr;
   logic [COUNT_BITS-1:0]    rd_index;

   // restoring division, STEP_BITS quotient bits per cycle
   always_comb begin
      div_work = work_ff;
      div_rem = {1'b0, rem_ff};
      for (int i = 0; i < STEP_BITS; i++) begin
         div_rem = {div_rem[RADIX_BITS-1:0], div_work[PAD_BITS-1]};
         div_work = {div_work[PAD_BITS-2:0], 1'b0};
         if (div_rem >= {1'b0, base_ff}) begin
            div_rem = div_rem - {1'b0, base_ff};
            div_work[0] = 1'b1;
         end
      end
   end

   assign digit_done = (step_ff == STEP_CNT_BITS'(STEPS_PER_DIGIT - 1));
   assign wr_en = (state_ff == S_DIVIDE) && digit_done;
   assign wr_addr = idx_ff[ADDR_BITS-1:0];
   assign rd_index = idx_in - COUNT_BITS'(1);
   assign rd_addr = rd_index[ADDR_BITS-1:0];

   // sequencer: divide, then the sign for a negative value, then digits most significant first
   always_comb begin
      state_in = state_ff;
      work_in = work_ff;
      rem_in = rem_ff;
      base_in = base_ff;
      neg_in = neg_ff;
      step_in = step_ff;
      idx_in = idx_ff;
      job_take = 1'b0;
      rsp_strobe = 1'b0;
      rsp_data.text_char = CHAR_MINUS;
      rsp_data.last_char = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (job_ready) begin
               job_take = 1'b1;
               work_in = PAD_BITS'(job_word.magnitude);
               base_in = job_word.base;
               neg_in = job_word.negative;
               rem_in = '0;
               step_in = '0;
               idx_in = '0;
               state_in = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            work_in = div_work;
            rem_in = div_rem[RADIX_BITS-1:0];
            step_in = step_ff + STEP_CNT_BITS'(1);
            if (digit_done) begin
               rem_in = '0;
               step_in = '0;
               idx_in = idx_ff + COUNT_BITS'(1);
               if (div_work == '0 || idx_ff == COUNT_BITS'(VALUE_BITS - 1)) begin
                  state_in = neg_ff ? S_SIGN : S_FETCH;
               end
            end
         end
         S_SIGN: begin
            rsp_strobe = 1'b1;
            rsp_data.text_char = CHAR_MINUS;
            rsp_data.last_char = 1'b0;
            state_in = S_EMIT;
         end
         S_FETCH: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            rsp_strobe = 1'b1;
            rsp_data.text_char = digit_char(rd_data_ff);
            rsp_data.last_char = (idx_ff == COUNT_BITS'(1));
            idx_in = idx_ff - COUNT_BITS'(1);
            if (idx_ff == COUNT_BITS'(1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= '0;
         idx_ff <= '0;
         neg_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         idx_ff <= idx_in;
         neg_ff <= neg_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff <= rem_in;
      base_ff <= base_in;
   end

   // digit store, least significant digit first
   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_mem[wr_addr] <= div_rem[RADIX_BITS-1:0];
      end
      rd_data_ff <= digit_mem[rd_addr];
   end

   // remainder always below the base while dividing
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVIDE) |-> (rem_ff < base_ff))
      else $error("remainder reached the base");

   // digit index never runs past the store
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVIDE) |-> (idx_ff < COUNT_BITS'(VALUE_BITS)))
      else $error("digit index beyond the store");

   // at least one digit follows the sign
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SIGN) |-> (idx_ff != '0))
      else $error("sign without digits");

   // the last character returns the back end to idle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last_char) |=> (state_ff == S_IDLE))
      else $error("text continued after last character");

endmodule

// File: sv/integer_to_text_any_base.sv
// Integer to text in any base from 2 to 36.
// Input channel: drive req_data (value, radix) and raise start; the word is
// taken at a rising edge where start is high and busy is low. A radix below
// 2 is used as 2, above 36 as 36.
// Result channel: one ASCII character per cycle on rsp_data while
// rsp_strobe is high, most significant first: a '-' for negative values,
// then digits 0-9 and A-Z; last_char marks the final character. Zero gives
// a single '0'. The receiver cannot stall; every strobe is a delivered word.
// Flow: a front stage classifies the word (sign, magnitude, base) into a
// two-entry queue, so up to two numbers can wait while one is converted.
// The back end takes a number from the queue, divides by the base 8
// quotient bits per cycle, passes through a sign state for a negative
// value or a digit fetch state otherwise, then emits. A number accepted
// into an empty, idle block is taken in the cycle after it is accepted.
// Reset clears the queue and the sequencer; no clearing pass is needed.
module integer_to_text_any_base
   import i2t_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   job_type front_job;
   job_type back_job;
   logic    q_empty;
   logic    q_full;
   logic    back_take;

   // front: classify the word
   i2t_front u_front (
      .req_word (req_data),
      .job_word (front_job)
   );

   // queue between front and back
   i2t_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (start),
      .push_word (front_job),
      .pop       (back_take),
      .pop_word  (back_job),
      .empty     (q_empty),
      .full      (q_full)
   );

   // back: divide and emit
   i2t_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_ready  (!q_empty),
      .job_word   (back_job),
      .job_take   (back_take),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   assign busy = q_full;

endmodule
